// ===== rtl/core/postfix_stack_evaluator_unit_assert.svh =====
// Assertion macros used by the checker file of the postfix stack evaluator.
`ifndef POSTFIX_STACK_EVALUATOR_UNIT_ASSERT_SVH
`define POSTFIX_STACK_EVALUATOR_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent, outside reset.
`define PSE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent, outside reset.
`define PSE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent, reset included.
`define PSE_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/pse_pkg.sv =====
// Shared constants, codes and the control store of the postfix stack evaluator.
`timescale 1ns / 1ps

package pse_pkg;

  // Stack geometry and field widths.
  localparam int STACK_DEPTH = 16;
  localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int DATA_W      = 64;
  localparam int HALF_W      = DATA_W / 2;
  localparam int KIND_W      = 3;
  localparam int STATUS_W    = 2;

  // Token kinds.
  localparam logic [KIND_W-1:0] KIND_LITERAL  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_VARIABLE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ADD      = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SUB      = 3'd3;
  localparam logic [KIND_W-1:0] KIND_MUL      = 3'd4;
  localparam logic [KIND_W-1:0] KIND_POW      = 3'd5;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd2;

  // Control store geometry.
  localparam int UPC_W  = 5;
  localparam int ACT_W  = 4;
  localparam int COND_W = 4;

  // Step addresses of the program.
  localparam logic [UPC_W-1:0] S_DISPATCH = 5'd0;
  localparam logic [UPC_W-1:0] S_PUSH     = 5'd1;
  localparam logic [UPC_W-1:0] S_OPCHK    = 5'd2;
  localparam logic [UPC_W-1:0] S_RDA      = 5'd3;
  localparam logic [UPC_W-1:0] S_LDA      = 5'd4;
  localparam logic [UPC_W-1:0] S_MUL      = 5'd5;
  localparam logic [UPC_W-1:0] S_MWAIT    = 5'd6;
  localparam logic [UPC_W-1:0] S_WRITE    = 5'd7;
  localparam logic [UPC_W-1:0] S_ADDSUB   = 5'd8;
  localparam logic [UPC_W-1:0] S_PINIT    = 5'd9;
  localparam logic [UPC_W-1:0] S_PTEST    = 5'd10;
  localparam logic [UPC_W-1:0] S_PBIT     = 5'd11;
  localparam logic [UPC_W-1:0] S_PMR      = 5'd12;
  localparam logic [UPC_W-1:0] S_PWR      = 5'd13;
  localparam logic [UPC_W-1:0] S_PSQ      = 5'd14;
  localparam logic [UPC_W-1:0] S_PSW      = 5'd15;
  localparam logic [UPC_W-1:0] S_FRD      = 5'd16;
  localparam logic [UPC_W-1:0] S_EMIT     = 5'd17;

  // Datapath actions.
  localparam logic [ACT_W-1:0] A_NOP      = 4'd0;
  localparam logic [ACT_W-1:0] A_PUSH     = 4'd1;
  localparam logic [ACT_W-1:0] A_CHECK    = 4'd2;
  localparam logic [ACT_W-1:0] A_RD_A     = 4'd3;
  localparam logic [ACT_W-1:0] A_LD_A     = 4'd4;
  localparam logic [ACT_W-1:0] A_MUL_AB   = 4'd5;
  localparam logic [ACT_W-1:0] A_CAP_RES  = 4'd6;
  localparam logic [ACT_W-1:0] A_WRITE    = 4'd7;
  localparam logic [ACT_W-1:0] A_ALU      = 4'd8;
  localparam logic [ACT_W-1:0] A_POW_INIT = 4'd9;
  localparam logic [ACT_W-1:0] A_MUL_RB   = 4'd10;
  localparam logic [ACT_W-1:0] A_MUL_BB   = 4'd11;
  localparam logic [ACT_W-1:0] A_CAP_BASE = 4'd12;
  localparam logic [ACT_W-1:0] A_EMIT     = 4'd13;

  // Branch conditions.
  localparam logic [COND_W-1:0] C_NEXT    = 4'd0;
  localparam logic [COND_W-1:0] C_ALWAYS  = 4'd1;
  localparam logic [COND_W-1:0] C_DISP    = 4'd2;
  localparam logic [COND_W-1:0] C_UNDER   = 4'd3;
  localparam logic [COND_W-1:0] C_OPSEL   = 4'd4;
  localparam logic [COND_W-1:0] C_MULDONE = 4'd5;
  localparam logic [COND_W-1:0] C_EXPNP   = 4'd6;
  localparam logic [COND_W-1:0] C_EXPZERO = 4'd7;
  localparam logic [COND_W-1:0] C_BITCLR  = 4'd8;
  localparam logic [COND_W-1:0] C_NOTLAST = 4'd9;
  localparam logic [COND_W-1:0] C_OUTFREE = 4'd10;

  // One control word: what the datapath does and where the program goes.
  typedef struct packed {
    logic [ACT_W-1:0]  act;
    logic [COND_W-1:0] cond;
    logic [UPC_W-1:0]  target;
  } uword_t;

  // Read-only program.
  function automatic uword_t ucode(input logic [UPC_W-1:0] step);
    uword_t w;
    case (step)
      S_DISPATCH: w = '{A_NOP,      C_DISP,    S_DISPATCH};
      S_PUSH:     w = '{A_PUSH,     C_ALWAYS,  S_FRD};
      S_OPCHK:    w = '{A_CHECK,    C_UNDER,   S_FRD};
      S_RDA:      w = '{A_RD_A,     C_NEXT,    S_DISPATCH};
      S_LDA:      w = '{A_LD_A,     C_OPSEL,   S_DISPATCH};
      S_MUL:      w = '{A_MUL_AB,   C_NEXT,    S_DISPATCH};
      S_MWAIT:    w = '{A_CAP_RES,  C_MULDONE, S_WRITE};
      S_WRITE:    w = '{A_WRITE,    C_ALWAYS,  S_FRD};
      S_ADDSUB:   w = '{A_ALU,      C_ALWAYS,  S_WRITE};
      S_PINIT:    w = '{A_POW_INIT, C_EXPNP,   S_WRITE};
      S_PTEST:    w = '{A_NOP,      C_EXPZERO, S_WRITE};
      S_PBIT:     w = '{A_NOP,      C_BITCLR,  S_PSQ};
      S_PMR:      w = '{A_MUL_RB,   C_NEXT,    S_DISPATCH};
      S_PWR:      w = '{A_CAP_RES,  C_MULDONE, S_PSQ};
      S_PSQ:      w = '{A_MUL_BB,   C_NEXT,    S_DISPATCH};
      S_PSW:      w = '{A_CAP_BASE, C_MULDONE, S_PTEST};
      S_FRD:      w = '{A_NOP,      C_NOTLAST, S_DISPATCH};
      S_EMIT:     w = '{A_EMIT,     C_OUTFREE, S_DISPATCH};
      default:    w = '{A_NOP,      C_ALWAYS,  S_DISPATCH};
    endcase
    return w;
  endfunction

  // Entry step for a freshly accepted token.
  function automatic logic [UPC_W-1:0] disp_step(input logic [KIND_W-1:0] k);
    logic [UPC_W-1:0] s;
    case (k)
      KIND_LITERAL, KIND_VARIABLE:          s = S_PUSH;
      KIND_ADD, KIND_SUB, KIND_MUL, KIND_POW: s = S_OPCHK;
      default:                              s = S_FRD;
    endcase
    return s;
  endfunction

  // Operator step once both operands are loaded.
  function automatic logic [UPC_W-1:0] opsel_step(input logic [KIND_W-1:0] k);
    logic [UPC_W-1:0] s;
    case (k)
      KIND_MUL: s = S_MUL;
      KIND_POW: s = S_PINIT;
      default:  s = S_ADDSUB;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/core/pse_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pse_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/pse_mul.sv =====
// Iterative 64-bit wrapping multiplier built on one shared 32x32 multiplier.
`timescale 1ns / 1ps

module pse_mul (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [pse_pkg::DATA_W-1:0] x,
  input  logic [pse_pkg::DATA_W-1:0] y,
  output logic                       done,
  output logic [pse_pkg::DATA_W-1:0] p
);
  import pse_pkg::*;

  logic [DATA_W-1:0] x_r;
  logic [DATA_W-1:0] y_r;
  logic [1:0]        cnt;
  logic              busy;
  logic [DATA_W-1:0] pp0;
  logic [HALF_W-1:0] pp1;
  logic [HALF_W-1:0] pp2;
  logic [HALF_W-1:0] ma;
  logic [HALF_W-1:0] mb;
  logic [DATA_W-1:0] prod;
  logic [HALF_W-1:0] cross_sum;

  // Operand select: low by low, then the two cross terms.
  always_comb begin
    case (cnt)
      2'd0: begin
        ma = x_r[HALF_W-1:0];
        mb = y_r[HALF_W-1:0];
      end
      2'd1: begin
        ma = x_r[HALF_W-1:0];
        mb = y_r[DATA_W-1:HALF_W];
      end
      default: begin
        ma = x_r[DATA_W-1:HALF_W];
        mb = y_r[HALF_W-1:0];
      end
    endcase
  end

  assign prod      = DATA_W'(ma) * DATA_W'(mb);
  assign cross_sum = pp1 + pp2;

  // Sequencing control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      done <= busy && (cnt == 2'd3);
      if (start) begin
        busy <= 1'b1;
        cnt  <= 2'd0;
      end else if (busy) begin
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Partial products; only the low half of each cross term reaches the result.
  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= x;
      y_r <= y;
    end
    if (busy) begin
      case (cnt)
        2'd0:    pp0 <= prod;
        2'd1:    pp1 <= prod[HALF_W-1:0];
        2'd2:    pp2 <= prod[HALF_W-1:0];
        default: p   <= pp0 + {cross_sum, {HALF_W{1'b0}}};
      endcase
    end
  end

endmodule

// ===== rtl/core/postfix_stack_evaluator_unit.sv =====
// Top level of the postfix stack evaluator: control-store sequencer and datapath.
//
// Usage:
//   Tokens enter on token_valid / token_stall with fields kind, literal, last.
//   A token is taken when token_valid is high and token_stall is low. The block
//   works on one token at a time and raises token_stall until it is done.
//   A token with last set yields one result on result_valid / result_stall
//   (value, status) and then empties the stack and clears the error status.
//   The variable value is written on var_valid / var_ready; var_ready is
//   always high, and writes are expected only while the block is idle.
// Each token runs through steps of the control program. Power runs a square
//   for every exponent bit and a multiply for every set bit, all through
//   the one shared multiplier. A last token adds an emit step for the
//   result. The result sits in an output register.
// While result_stall holds a result, the next tokens are still taken; a last
//   token then waits in its emit step until the output register frees.
// Reset is synchronous: the stack level, error status, variable value and
//   the output valid clear, and the program returns to its dispatch step.
`timescale 1ns / 1ps

module postfix_stack_evaluator_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         token_valid,
  output logic                         token_stall,
  input  logic [pse_pkg::KIND_W-1:0]   kind,
  input  logic [pse_pkg::DATA_W-1:0]   literal,
  input  logic                         last,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic [pse_pkg::DATA_W-1:0]   value,
  output logic [pse_pkg::STATUS_W-1:0] status,
  input  logic                         var_valid,
  output logic                         var_ready,
  input  logic [pse_pkg::DATA_W-1:0]   variable_value
);
  import pse_pkg::*;

  logic [UPC_W-1:0]    upc;
  logic [UPC_W-1:0]    upc_next;
  uword_t              uw;
  logic [LEVEL_W-1:0]  level;
  logic [LEVEL_W-1:0]  lvl_m1;
  logic [LEVEL_W-1:0]  lvl_m2;
  logic [STATUS_W-1:0] err;
  logic [DATA_W-1:0]   var_reg;
  logic [KIND_W-1:0]   kind_r;
  logic [DATA_W-1:0]   lit_r;
  logic                last_r;
  logic [DATA_W-1:0]   opa;
  logic [DATA_W-1:0]   opb;
  logic [DATA_W-1:0]   res;
  logic                accept;
  logic                full;
  logic                lt2;
  logic                out_free;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [DATA_W-1:0]   ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [DATA_W-1:0]   ram_rdata;
  logic                mul_start;
  logic [DATA_W-1:0]   mul_x;
  logic [DATA_W-1:0]   mul_y;
  logic                mul_done;
  logic [DATA_W-1:0]   mul_p;

  // Handshakes and stack pointer arithmetic.
  assign token_stall = rst || (upc != S_DISPATCH);
  assign accept      = token_valid && !token_stall;
  assign var_ready   = 1'b1;
  assign out_free    = !result_valid || !result_stall;
  assign lvl_m1      = level - LEVEL_W'(1);
  assign lvl_m2      = level - LEVEL_W'(2);
  assign full        = (level == LEVEL_W'(STACK_DEPTH));
  assign lt2         = (level < LEVEL_W'(2));
  assign uw          = ucode(upc);

  // Next step from the branch condition of the current control word.
  always_comb begin
    case (uw.cond)
      C_NEXT:    upc_next = upc + UPC_W'(1);
      C_ALWAYS:  upc_next = uw.target;
      C_DISP:    upc_next = accept ? disp_step(kind) : upc;
      C_UNDER:   upc_next = lt2 ? uw.target : upc + UPC_W'(1);
      C_OPSEL:   upc_next = opsel_step(kind_r);
      C_MULDONE: upc_next = mul_done ? uw.target : upc;
      C_EXPNP:   upc_next = (opb[DATA_W-1] || (opb == '0)) ? uw.target : upc + UPC_W'(1);
      C_EXPZERO: upc_next = (opb == '0) ? uw.target : upc + UPC_W'(1);
      C_BITCLR:  upc_next = !opb[0] ? uw.target : upc + UPC_W'(1);
      C_NOTLAST: upc_next = !last_r ? uw.target : upc + UPC_W'(1);
      C_OUTFREE: upc_next = out_free ? uw.target : upc;
      default:   upc_next = S_DISPATCH;
    endcase
  end

  // Stack memory port control.
  always_comb begin
    ram_we    = ((uw.act == A_PUSH) && !full) || (uw.act == A_WRITE);
    ram_waddr = (uw.act == A_WRITE) ? lvl_m2[ADDR_W-1:0] : level[ADDR_W-1:0];
    if (uw.act == A_WRITE) begin
      ram_wdata = res;
    end else if (kind_r == KIND_LITERAL) begin
      ram_wdata = lit_r;
    end else begin
      ram_wdata = var_reg;
    end
    ram_raddr = (uw.act == A_RD_A) ? lvl_m2[ADDR_W-1:0] : lvl_m1[ADDR_W-1:0];
  end

  // Multiplier operand selection.
  always_comb begin
    mul_start = uw.act inside {A_MUL_AB, A_MUL_RB, A_MUL_BB};
    case (uw.act)
      A_MUL_RB: begin
        mul_x = res;
        mul_y = opa;
      end
      A_MUL_BB: begin
        mul_x = opa;
        mul_y = opa;
      end
      default: begin
        mul_x = opa;
        mul_y = opb;
      end
    endcase
  end

  // Control state: step counter, stack level, error status, variable value, output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      upc          <= S_DISPATCH;
      level        <= '0;
      err          <= STATUS_OK;
      var_reg      <= '0;
      result_valid <= 1'b0;
    end else begin
      upc <= upc_next;
      if (var_valid && var_ready) begin
        var_reg <= variable_value;
      end
      if ((uw.act == A_EMIT) && out_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      case (uw.act)
        A_PUSH: begin
          if (!full) begin
            level <= level + LEVEL_W'(1);
          end else if (err == STATUS_OK) begin
            err <= STATUS_OVERFLOW;
          end
        end
        A_CHECK: begin
          if (lt2 && (err == STATUS_OK)) begin
            err <= STATUS_UNDERFLOW;
          end
        end
        A_WRITE: begin
          level <= lvl_m1;
        end
        A_EMIT: begin
          if (out_free) begin
            level <= '0;
            err   <= STATUS_OK;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= kind;
      lit_r  <= literal;
      last_r <= last;
    end
    case (uw.act)
      A_RD_A: begin
        opb <= ram_rdata;
      end
      A_LD_A: begin
        opa <= ram_rdata;
      end
      A_ALU: begin
        res <= (kind_r == KIND_SUB) ? opa - opb : opa + opb;
      end
      A_POW_INIT: begin
        res <= DATA_W'(1);
      end
      A_CAP_RES: begin
        if (mul_done) begin
          res <= mul_p;
        end
      end
      A_CAP_BASE: begin
        if (mul_done) begin
          opa <= mul_p;
          opb <= opb >> 1;
        end
      end
      A_EMIT: begin
        if (out_free) begin
          if (err != STATUS_OK) begin
            value  <= '0;
            status <= err;
          end else if (level == '0) begin
            value  <= '0;
            status <= STATUS_UNDERFLOW;
          end else begin
            value  <= ram_rdata;
            status <= STATUS_OK;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Stack storage.
  pse_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Shared multiplier for multiply and power.
  pse_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .x     (mul_x),
    .y     (mul_y),
    .done  (mul_done),
    .p     (mul_p)
  );

endmodule

// ===== rtl/core/pse_checker.sv =====
// Port-level assertion checker for the postfix stack evaluator, with its bind.
`timescale 1ns / 1ps
`include "postfix_stack_evaluator_unit_assert.svh"

module pse_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         token_valid,
  input logic                         token_stall,
  input logic                         result_valid,
  input logic                         result_stall,
  input logic [pse_pkg::DATA_W-1:0]   value,
  input logic [pse_pkg::STATUS_W-1:0] status
);
  import pse_pkg::*;

  // A stalled result keeps its valid and its payload.
  `PSE_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && result_stall, result_valid && $stable(value) && $stable(status), "stalled result changed")

  // An error result always carries a zero value.
  `PSE_ASSERT_NOW(a_error_zero, clk, rst, result_valid && (status != STATUS_OK), value == '0, "error result with nonzero value")

  // Tokens are worked one at a time: an accepted token closes the input.
  `PSE_ASSERT_NEXT(a_one_at_a_time, clk, rst, token_valid && !token_stall, token_stall, "token taken while busy")

  // Reset leaves no result pending.
  `PSE_ASSERT_NEXT_ALWAYS(a_reset_clear, clk, rst, !result_valid, "result valid after reset")

endmodule

bind postfix_stack_evaluator_unit pse_checker u_pse_checker (
  .clk          (clk),
  .rst          (rst),
  .token_valid  (token_valid),
  .token_stall  (token_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .value        (value),
  .status       (status)
);

// ===== tb/sv/postfix_stack_evaluator_unit_tb.sv =====
// Self-checking testbench of the postfix stack evaluator: directed tokens, then random expressions, noise and floods.
`timescale 1ns / 1ps

module postfix_stack_evaluator_unit_tb;
  import pse_pkg::*;

  // Kinds the block must ignore apart from their last flag.
  localparam logic [KIND_W-1:0] KIND_SPARE6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE7 = 3'd7;

  localparam logic [DATA_W-1:0] MAX_POS  = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] MIN_NEG  = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};
  localparam logic [DATA_W-1:0] ZERO     = {DATA_W{1'b0}};

  localparam int     MAX_GAP       = 13;
  localparam int     SETTLE_CYCLES = 1000;
  localparam int     PHASE_ITEMS   = 240;
  localparam int     NUM_PHASES    = 6;
  localparam longint CYCLE_LIMIT   = 6_000_000;

  typedef struct packed {
    logic [DATA_W-1:0]   value;
    logic [STATUS_W-1:0] status;
  } result_t;

  // One line of the directed table; the token repeats rep times, last only on the final one.
  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [DATA_W-1:0]   lit;
    bit                  lst;
    int                  rep;
    bit                  typed;
    logic [DATA_W-1:0]   tval;
    logic [STATUS_W-1:0] tstat;
  } token_row_t;

  // Clock, reset and block inputs, all known from time zero.
  logic                clk            = 1'b0;
  logic                rst            = 1'b1;
  logic                token_valid    = 1'b0;
  logic [KIND_W-1:0]   kind           = KIND_LITERAL;
  logic [DATA_W-1:0]   literal        = ZERO;
  logic                last           = 1'b0;
  logic                result_stall   = 1'b0;
  logic                var_valid      = 1'b0;
  logic [DATA_W-1:0]   variable_value = ZERO;
  logic                token_stall;
  logic                result_valid;
  logic [DATA_W-1:0]   value;
  logic [STATUS_W-1:0] status;
  logic                var_ready;

  // Shadow calculator state.
  logic [DATA_W-1:0]   calc_stack [STACK_DEPTH];
  int unsigned         calc_level = 0;
  logic [STATUS_W-1:0] calc_error = STATUS_OK;
  logic [DATA_W-1:0]   calc_var   = ZERO;

  result_t pending_results [$];
  int      fail_count     = 0;
  int      sent_items     = 0;
  int      stall_left     = 0;
  bit      sender_idle    = 1'b1;
  bit      receiver_idle  = 1'b1;
  longint  cycle_count    = 0;

  token_row_t directed_rows [31] = '{
    // The variable holds its reset value of zero.
    '{KIND_VARIABLE, ALL_ONES, 1'b1, 1, 1'b1, ZERO, STATUS_OK},
    // Add wraps past the largest positive value.
    '{KIND_LITERAL, MAX_POS, 1'b0, 1, 1'b0, ZERO, STATUS_OK},
    '{KIND_LITERAL, 64'd1, 1'b0, 1, 1'b0, ZERO, STATUS_OK},
    '{KIND_ADD, ZERO, 1'b1, 1, 1'b1, MIN_NEG, STATUS_OK},
    // Operator on an empty stack, then a final token on an empty stack.
    '{KIND_SUB, ALL_ONES, 1'b1, 1, 1'b1, ZERO, STATUS_UNDERFLOW},
    '{KIND_SPARE6, ZERO, 1'b1, 1, 1'b1, ZERO, STATUS_UNDERFLOW},
    // Subtract wraps below the most negative value.
    '{KIND_LITERAL, MIN_NEG, 1'b0, 1, 1'b0, ZERO, STATUS_OK},
    '{KIND_LITERAL, 64'd1, 1'b0, 1, 1'b0, ZERO, STATUS_OK},
    '{KIND_SUB, ZERO, 1'b1, 1, 1'b1, MAX_POS, STATUS_OK},
    // A negative exponent gives one.
    '{KIND_LITERAL, 64'd3, 1'b0, 1, 1'b0, ZERO, STATUS_OK},
    '{KIND_LITERAL, ALL_ONES, 1'b0, 1, 1'b0, ZERO, STATUS_OK},
    '{KIND_POW, ZERO, 1'b1, 1, 1'b1, 64'd1, STATUS_OK},
    // Zero exponent, an ignored kind, a multiply, and leftover entries below the top.
    '{KIND_LITERAL, 64'hDEAD_BEEF_0123_4567, 1'b0, 1, 1'b0, ZERO, STATUS_OK},
    '{KIND_LITERAL, ZERO, 1'b0, 1, 1'b0, ZERO, STATUS_OK},
    '{KIND_POW, ZERO, 1'b0, 1, 1'b0, ZERO, STATUS_OK},
    '{KIND_SPARE7, ALL_ONES, 1'b0, 1, 1'b0, ZERO, STATUS_OK},
    '{KIND_LITERAL, 64'hFFFF_FFFF_FFFF_FFF9, 1'b0, 1, 1'b0, ZERO, STATUS_OK},
    '{KIND_MUL, ZERO, 1'b0, 1, 1'b0, ZERO, STATUS_OK},
    '{KIND_LITERAL, 64'd3, 1'b0, 1, 1'b0, ZERO, STATUS_OK},
    '{KIND_LITERAL, 64'd5, 1'b0, 1, 1'b0, ZERO, STATUS_OK},
    '{KIND_POW, ZERO, 1'b1, 1, 1'b1, 64'd243, STATUS_OK},
    // The longest exponent the block can see.
    '{KIND_LITERAL, 64'h5555_5555_5555_5555, 1'b0, 1, 1'b0, ZERO, STATUS_OK},
    '{KIND_LITERAL, MAX_POS, 1'b0, 1, 1'b0, ZERO, STATUS_OK},
    '{KIND_POW, ZERO, 1'b1, 1, 1'b0, ZERO, STATUS_OK},
    // Operator with a single entry.
    '{KIND_LITERAL, 64'd5, 1'b0, 1, 1'b0, ZERO, STATUS_OK},
    '{KIND_MUL, ZERO, 1'b1, 1, 1'b1, ZERO, STATUS_UNDERFLOW},
    // Push onto a full stack; the error outlives a later good add.
    '{KIND_LITERAL, MAX_POS, 1'b0, STACK_DEPTH, 1'b0, ZERO, STATUS_OK},
    '{KIND_VARIABLE, ZERO, 1'b0, 1, 1'b0, ZERO, STATUS_OK},
    '{KIND_ADD, ZERO, 1'b1, 1, 1'b1, ZERO, STATUS_OVERFLOW},
    // Multiply wraps: the most negative value times minus one.
    '{KIND_LITERAL, MIN_NEG, 1'b0, 1, 1'b0, ZERO, STATUS_OK},
    '{KIND_LITERAL, ALL_ONES, 1'b0, 1, 1'b0, ZERO, STATUS_OK}
  };

  postfix_stack_evaluator_unit dut (
    .clk            (clk),
    .rst            (rst),
    .token_valid    (token_valid),
    .token_stall    (token_stall),
    .kind           (kind),
    .literal        (literal),
    .last           (last),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .value          (value),
    .status         (status),
    .var_valid      (var_valid),
    .var_ready      (var_ready),
    .variable_value (variable_value)
  );

  always #6 clk = ~clk;

  // Wrapped power by square-and-multiply; zero or negative exponents give one.
  function automatic logic [DATA_W-1:0] wrap_power(input logic [DATA_W-1:0] base,
                                                   input logic [DATA_W-1:0] ex);
    logic [DATA_W-1:0] acc;
    acc = 64'd1;
    if (ex[DATA_W-1] || ex == ZERO) return acc;
    while (ex != ZERO) begin
      if (ex[0]) acc = acc * base;
      base = base * base;
      ex   = ex >> 1;
    end
    return acc;
  endfunction

  // Applies one token to the shadow stack; returns 1 when it yields a result.
  function automatic bit eval_token(input logic [KIND_W-1:0] k, input logic [DATA_W-1:0] lit,
                                    input bit lst, output result_t res);
    logic [DATA_W-1:0] opa, opb, outv;
    res  = '0;
    outv = ZERO;
    case (k)
      KIND_LITERAL, KIND_VARIABLE: begin
        if (calc_level >= STACK_DEPTH) begin
          if (calc_error == STATUS_OK) calc_error = STATUS_OVERFLOW;
        end else begin
          calc_stack[calc_level] = (k == KIND_LITERAL) ? lit : calc_var;
          calc_level++;
        end
      end
      KIND_ADD, KIND_SUB, KIND_MUL, KIND_POW: begin
        if (calc_level < 2) begin
          if (calc_error == STATUS_OK) calc_error = STATUS_UNDERFLOW;
        end else begin
          opb = calc_stack[calc_level-1];
          opa = calc_stack[calc_level-2];
          case (k)
            KIND_ADD: outv = opa + opb;
            KIND_SUB: outv = opa - opb;
            KIND_MUL: outv = opa * opb;
            default:  outv = wrap_power(opa, opb);
          endcase
          calc_level--;
          calc_stack[calc_level-1] = outv;
        end
      end
      default: ;
    endcase
    if (!lst) return 1'b0;
    if (calc_error != STATUS_OK) res = '{ZERO, calc_error};
    else if (calc_level == 0) res = '{ZERO, STATUS_UNDERFLOW};
    else res = '{calc_stack[calc_level-1], STATUS_OK};
    calc_level = 0;
    calc_error = STATUS_OK;
    return 1'b1;
  endfunction

  // Appends one expected result behind the ones already waiting.
  function automatic void queue_expected(input result_t r);
    pending_results = {pending_results, r};
  endfunction

  // Mostly small operands, some extremes, some full-width noise.
  function automatic logic [DATA_W-1:0] pick_operand();
    logic [DATA_W-1:0] t;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        t = DATA_W'($urandom_range(0, 40));
        t = t - 64'd20;
      end
      5: begin
        case ($urandom_range(0, 4))
          0:       t = ZERO;
          1:       t = 64'd1;
          2:       t = ALL_ONES;
          3:       t = MAX_POS;
          default: t = MIN_NEG;
        endcase
      end
      default: t = {$urandom, $urandom};
    endcase
    return t;
  endfunction

  function automatic logic [KIND_W-1:0] pick_operator();
    logic [KIND_W-1:0] k;
    case ($urandom_range(0, 9))
      0, 1, 2: k = KIND_ADD;
      3, 4, 5: k = KIND_SUB;
      6, 7:    k = KIND_MUL;
      default: k = KIND_POW;
    endcase
    return k;
  endfunction

  // Offers one token after a random gap and records what it should produce.
  task automatic send_token(input logic [KIND_W-1:0] k, input logic [DATA_W-1:0] lit,
                            input bit lst, input bit typed, input result_t typed_res);
    int      gap;
    bit      yields;
    result_t res;
    gap = sender_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      token_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    token_valid <= 1'b1;
    kind        <= k;
    literal     <= lit;
    last        <= lst;
    do @(posedge clk); while (token_stall);
    yields = eval_token(k, lit, lst, res);
    if (yields) queue_expected(typed ? typed_res : res);
    if (k <= KIND_POW) sent_items++;
  endtask

  task automatic send_push(input bit lst);
    if ($urandom_range(0, 6) == 0) send_token(KIND_VARIABLE, {$urandom, $urandom}, lst, 1'b0, '0);
    else send_token(KIND_LITERAL, pick_operand(), lst, 1'b0, '0);
  endtask

  // A well-formed expression, now and then with extra entries left below the top.
  task automatic send_expression();
    int operands, pushes_left, ops_left, depth;
    bit fin;
    operands    = ($urandom_range(0, 3) == 0) ? $urandom_range(1, STACK_DEPTH)
                                              : $urandom_range(1, 5);
    pushes_left = operands;
    ops_left    = operands - 1;
    depth       = 0;
    if (ops_left > 0 && $urandom_range(0, 7) == 0) ops_left = ops_left - 1;
    while (pushes_left + ops_left > 0) begin
      fin = (pushes_left + ops_left == 1);
      if (depth >= 2 && ops_left > 0 && (pushes_left == 0 || $urandom_range(0, 1))) begin
        send_token(pick_operator(), {$urandom, $urandom}, fin, 1'b0, '0);
        ops_left--;
        depth--;
      end else begin
        send_push(fin);
        pushes_left--;
        depth++;
      end
    end
  endtask

  // Random kinds in random order, with stray last flags.
  task automatic send_noise();
    int                n;
    logic [DATA_W-1:0] lit;
    n = $urandom_range(1, 20);
    for (int i = 0; i < n; i++) begin
      lit = $urandom_range(0, 1) ? pick_operand() : {$urandom, $urandom};
      send_token(3'($urandom_range(0, 7)), lit,
                 (i == n - 1) || ($urandom_range(0, 15) == 0), 1'b0, '0);
    end
  endtask

  // Fills the stack to about its depth, maybe past it, then folds part of it.
  task automatic send_flood();
    int n, ops;
    n   = $urandom_range(STACK_DEPTH - 1, STACK_DEPTH + 2);
    ops = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) send_push(1'b0);
    for (int i = 0; i < ops; i++) send_token(pick_operator(), {$urandom, $urandom}, 1'b0, 1'b0, '0);
    send_token(pick_operator(), {$urandom, $urandom}, 1'b1, 1'b0, '0);
  endtask

  // Holds the token input idle until every result is back, optionally letting a
  // token that yields nothing run to completion as well.
  task automatic hold_until_drained(input bit settle);
    token_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_variable(input logic [DATA_W-1:0] v);
    var_valid      <= 1'b1;
    variable_value <= v;
    do @(posedge clk); while (!var_ready);
    var_valid <= 1'b0;
    calc_var  = v;
  endtask

  // Result side: compare each taken item with the oldest expectation and draw the next stall.
  always @(posedge clk) begin : result_check
    result_t got, want;
    if (!rst && result_valid && !result_stall) begin
      got = '{value, status};
      if (pending_results.size() == 0) begin
        $error("unexpected result: value %h status %0d", got.value, got.status);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.value !== want.value) begin
          $error("value: expected %h, actual %h", want.value, got.value);
          fail_count++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, got.status);
          fail_count++;
        end
      end
      stall_left = receiver_idle ? $urandom_range(0, MAX_GAP) : 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end
    result_stall <= (stall_left > 0);
  end

  // Guard against a hung block.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Main stimulus: reset, the directed table, then random phases under each variable setting.
  initial begin : stimulus
    logic [DATA_W-1:0] phase_vars [NUM_PHASES];
    int                target;
    int                reps;
    bit                paused;
    token_row_t        row;
    paused     = 1'b0;
    phase_vars = '{MAX_POS, MIN_NEG, ALL_ONES, 64'd2, {$urandom, $urandom}, ZERO};

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // The directed table runs with the variable at its reset value.
    foreach (directed_rows[i]) begin
      row  = directed_rows[i];
      reps = row.rep;
      for (int r = 0; r < reps; r++)
        send_token(row.kind, row.lit, row.lst && (r == reps - 1),
                   row.typed && (r == reps - 1), '{row.tval, row.tstat});
    end
    send_token(KIND_MUL, ZERO, 1'b1, 1'b1, '{MIN_NEG, STATUS_OK});

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      hold_until_drained(1'b1);
      write_variable(phase_vars[ph]);
      target = sent_items + PHASE_ITEMS;
      while (sent_items < target) begin
        sender_idle   = ($urandom_range(0, 3) != 0);
        receiver_idle = ($urandom_range(0, 3) != 0);
        // Once, let the pipeline empty out in the middle of a phase.
        if (ph == 2 && !paused && sent_items >= target - PHASE_ITEMS / 2) begin
          hold_until_drained(1'b0);
          paused = 1'b1;
        end
        case ($urandom_range(0, 19))
          0, 1, 2:  send_noise();
          3, 4:     send_flood();
          default:  send_expression();
        endcase
      end
    end

    hold_until_drained(1'b1);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/pse_pkg.sv
rtl/core/pse_ram.sv
rtl/core/pse_mul.sv
rtl/core/postfix_stack_evaluator_unit.sv
rtl/core/pse_checker.sv
tb/sv/postfix_stack_evaluator_unit_tb.sv
